// ===== design/adc_average_uart_sender_assert.svh =====
// ----------------------------------------------------------------------------
// ADC average UART sender assertion macros
// Concurrent check macros, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_AVERAGE_UART_SENDER_ASSERT_SVH
`define ADC_AVERAGE_UART_SENDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AAUS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aaus check failed");
`define AAUS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aaus check failed");
`else
`define AAUS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define AAUS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/aaus_pkg.sv =====
// ----------------------------------------------------------------------------
// ADC average UART sender package
// Shared constants and word types.
// ----------------------------------------------------------------------------
package aaus_pkg;

    localparam int unsigned SAMPLE_BITS  = 8;
    localparam int unsigned WINDOW_SHIFT = 5;
    localparam int unsigned SUM_BITS     = SAMPLE_BITS + WINDOW_SHIFT;
    localparam int unsigned BYTE_BITS    = 8;
    localparam int unsigned FRAME_BITS   = 2 * (BYTE_BITS + 2);
    localparam int unsigned LEFT_BITS    = $clog2(FRAME_BITS + 1);
    localparam int unsigned PERIOD_BITS  = 12;
    localparam int unsigned PERIOD_RESET = 52;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic tx_line;
        logic busy;
        logic overrun;
    } t_result;

endpackage

// ===== design/aaus_front.sv =====
// ----------------------------------------------------------------------------
// ADC average UART sender front end
// Accepts input words, decodes the command and registers them for the queue.
// ----------------------------------------------------------------------------
module aaus_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [aaus_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                           o_q_valid,
    input  logic                           i_q_ready,
    output aaus_pkg::t_item                o_q_item
);

    logic            r_valid;
    aaus_pkg::t_item r_item;
    aaus_pkg::t_item n_item;
    logic            accept;

    assign o_in_stall = r_valid && !i_q_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_item.op     = i_command ? aaus_pkg::OP_TICK : aaus_pkg::OP_SAMPLE;
        n_item.sample = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

// ===== design/aaus_queue.sv =====
// ----------------------------------------------------------------------------
// ADC average UART sender item queue
// Short FIFO that decouples the front end from the sender back end.
// ----------------------------------------------------------------------------
`include "adc_average_uart_sender_assert.svh"

module aaus_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  aaus_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output aaus_pkg::t_item o_item
);

    aaus_pkg::t_item                   r_mem [aaus_pkg::QUEUE_DEPTH];
    logic [aaus_pkg::QPTR_BITS-1:0]    r_wr_ptr;
    logic [aaus_pkg::QPTR_BITS-1:0]    r_rd_ptr;
    logic [aaus_pkg::QCNT_BITS-1:0]    r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_ready = r_count != aaus_pkg::QCNT_BITS'(aaus_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `AAUS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= aaus_pkg::QCNT_BITS'(aaus_pkg::QUEUE_DEPTH))
    `AAUS_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 1'b1)
    `AAUS_ASSERT_SAME(a_ptr_gap, i_clk, i_rst_n, r_count != '0 && r_count != aaus_pkg::QCNT_BITS'(aaus_pkg::QUEUE_DEPTH), r_wr_ptr != r_rd_ptr)

endmodule

// ===== design/aaus_back.sv =====
// ----------------------------------------------------------------------------
// ADC average UART sender back end
// Window averaging, 8N1 frame pair shifter and registered result word.
// ----------------------------------------------------------------------------
`include "adc_average_uart_sender_assert.svh"

module aaus_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [aaus_pkg::PERIOD_BITS-1:0] i_cfg_data,
    input  logic                             i_q_valid,
    input  aaus_pkg::t_item                  i_q_item,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output aaus_pkg::t_result                o_result
);

    logic [aaus_pkg::PERIOD_BITS-1:0]  r_bit_period;
    logic [aaus_pkg::SUM_BITS-1:0]     r_window_sum;
    logic [aaus_pkg::SUM_BITS-1:0]     n_window_sum;
    logic [aaus_pkg::WINDOW_SHIFT-1:0] r_window_count;
    logic [aaus_pkg::WINDOW_SHIFT-1:0] n_window_count;
    logic [aaus_pkg::FRAME_BITS-1:0]   r_frame_shift;
    logic [aaus_pkg::FRAME_BITS-1:0]   n_frame_shift;
    logic [aaus_pkg::LEFT_BITS-1:0]    r_bits_left;
    logic [aaus_pkg::LEFT_BITS-1:0]    n_bits_left;
    logic [aaus_pkg::PERIOD_BITS-1:0]  r_tick_count;
    logic [aaus_pkg::PERIOD_BITS-1:0]  n_tick_count;
    logic                              r_out_valid;
    aaus_pkg::t_result                 r_out;
    aaus_pkg::t_result                 n_out;
    logic                              take;
    logic [aaus_pkg::SUM_BITS-1:0]     sum_add;
    logic [aaus_pkg::BYTE_BITS-1:0]    avg;
    logic [aaus_pkg::PERIOD_BITS-1:0]  tick_inc;
    logic                              window_end;
    logic                              dropped;

    assign take    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = take;

    assign sum_add  = r_window_sum + aaus_pkg::SUM_BITS'(i_q_item.sample);
    assign avg      = sum_add[aaus_pkg::WINDOW_SHIFT +: aaus_pkg::BYTE_BITS];
    assign tick_inc = r_tick_count + 1'b1;
    assign window_end = &r_window_count;

    always_comb begin
        n_window_sum   = r_window_sum;
        n_window_count = r_window_count;
        n_frame_shift  = r_frame_shift;
        n_bits_left    = r_bits_left;
        n_tick_count   = r_tick_count;
        dropped        = 1'b0;
        case (i_q_item.op)
            aaus_pkg::OP_SAMPLE: begin
                n_window_sum   = sum_add;
                n_window_count = r_window_count + 1'b1;
                if (window_end) begin
                    n_window_sum = '0;
                    if (r_bits_left != '0) begin
                        dropped = 1'b1;
                    end else begin
                        n_frame_shift = {1'b1, ~avg, 1'b0, 1'b1, avg, 1'b0};
                        n_bits_left   = aaus_pkg::LEFT_BITS'(aaus_pkg::FRAME_BITS);
                        n_tick_count  = '0;
                    end
                end
            end
            aaus_pkg::OP_TICK: begin
                if (r_bits_left != '0) begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= r_bit_period) begin
                        n_tick_count  = '0;
                        n_frame_shift = {1'b1, r_frame_shift[aaus_pkg::FRAME_BITS-1:1]};
                        n_bits_left   = r_bits_left - 1'b1;
                    end
                end
            end
            default: begin
                n_tick_count = r_tick_count;
            end
        endcase
        n_out.busy    = n_bits_left != '0;
        n_out.tx_line = (n_bits_left != '0) ? n_frame_shift[0] : 1'b1;
        n_out.overrun = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period   <= aaus_pkg::PERIOD_BITS'(aaus_pkg::PERIOD_RESET);
            r_window_sum   <= '0;
            r_window_count <= '0;
            r_frame_shift  <= '1;
            r_bits_left    <= '0;
            r_tick_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bit_period <= i_cfg_data;
            end
            if (take) begin
                r_window_sum   <= n_window_sum;
                r_window_count <= n_window_count;
                r_frame_shift  <= n_frame_shift;
                r_bits_left    <= n_bits_left;
                r_tick_count   <= n_tick_count;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `AAUS_ASSERT_SAME(a_idle_line_mark, i_clk, i_rst_n, r_bits_left == '0, &r_frame_shift)
    `AAUS_ASSERT_SAME(a_overrun_busy, i_clk, i_rst_n, r_out_valid && r_out.overrun, r_out.busy)
    `AAUS_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, !take, $stable(r_window_count) && $stable(r_bits_left))
    `AAUS_ASSERT_SAME(a_left_bound, i_clk, i_rst_n, 1'b1, r_bits_left <= aaus_pkg::LEFT_BITS'(aaus_pkg::FRAME_BITS))

endmodule

// ===== design/adc_average_uart_sender.sv =====
// ----------------------------------------------------------------------------
// ADC average UART sender
// Boxcar average of 32 samples sent as a byte and its complement over 8N1.
// ----------------------------------------------------------------------------
// One input word is taken every clock cycle and gives one result word while
// neither o_in_stall nor i_out_stall holds it back; the back end updates its state once per word.
// A word passes the front register, the queue and the result register before
// its result reaches the output. Ticks advance the serial bit timer, samples
// accumulate; bit_period may only be written while no word is in flight.
module adc_average_uart_sender (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [aaus_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_tx_line,
    output logic                             o_sender_busy,
    output logic                             o_overrun,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [aaus_pkg::PERIOD_BITS-1:0] i_cfg_data
);

    logic              fq_valid;
    logic              fq_ready;
    aaus_pkg::t_item   fq_item;
    logic              qb_valid;
    logic              qb_pop;
    aaus_pkg::t_item   qb_item;
    aaus_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    aaus_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_sample   (i_sample),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_item   (fq_item)
    );

    aaus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_pop   (qb_pop),
        .o_item  (qb_item)
    );

    aaus_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (qb_valid),
        .i_q_item    (qb_item),
        .o_q_pop     (qb_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_tx_line     = result.tx_line;
    assign o_sender_busy = result.busy;
    assign o_overrun     = result.overrun;

endmodule

// ===== bench/adc_average_uart_sender_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC average UART sender testbench
// Feeds sample and tick words through a queue-fed driver under random
// gaps and output stalls, predicts the serial line state of every word
// from a local model of the 32-sample average and its two 8N1 frames,
// and checks each result word in order.
// ----------------------------------------------------------------------------
module adc_average_uart_sender_test;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 64;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    logic                             i_command   = 1'b0;
    logic [aaus_pkg::SAMPLE_BITS-1:0] i_sample    = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic                             o_tx_line;
    logic                             o_sender_busy;
    logic                             o_overrun;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [aaus_pkg::PERIOD_BITS-1:0] i_cfg_data  = '0;

    adc_average_uart_sender i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tx_line     (o_tx_line),
        .o_sender_busy (o_sender_busy),
        .o_overrun     (o_overrun),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the averager and serial sender
    logic [aaus_pkg::PERIOD_BITS-1:0] ticks_per_bit;
    logic [aaus_pkg::SUM_BITS-1:0]    win_sum;
    logic [5:0]                       win_count;
    logic [aaus_pkg::FRAME_BITS-1:0]  line_bits;
    logic [aaus_pkg::LEFT_BITS-1:0]   bits_to_go;
    logic [aaus_pkg::PERIOD_BITS-1:0] tick_in_bit;

    aaus_pkg::t_item   adc_tick_words [$];
    aaus_pkg::t_result line_states_due [$];

    int unsigned period_plan [10] = '{0, 2, 4095, 1, 3, 52, 5, 1, 2, 0};

    bit idle_on;
    bit stall_on;
    int gap_left;
    int stall_left;
    int error_count;
    int cycle_count;

    aaus_pkg::t_item   next_word;
    aaus_pkg::t_item   seen_word;
    aaus_pkg::t_result want;

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic aaus_pkg::t_result predict_line_state(input aaus_pkg::t_item word);
        logic [aaus_pkg::BYTE_BITS-1:0] avg;
        aaus_pkg::t_result              res;
        res.overrun = 1'b0;
        if (word.op == aaus_pkg::OP_SAMPLE) begin
            win_sum   = win_sum + aaus_pkg::SUM_BITS'(word.sample);
            win_count = win_count + 6'd1;
            if (win_count >= 6'(1 << aaus_pkg::WINDOW_SHIFT)) begin
                avg       = win_sum[aaus_pkg::SUM_BITS-1 -: aaus_pkg::BYTE_BITS];
                win_sum   = '0;
                win_count = '0;
                if (bits_to_go != 0) begin
                    res.overrun = 1'b1;
                end else begin
                    line_bits   = {1'b1, ~avg, 1'b0, 1'b1, avg, 1'b0};
                    bits_to_go  = aaus_pkg::LEFT_BITS'(aaus_pkg::FRAME_BITS);
                    tick_in_bit = '0;
                end
            end
        end else if (bits_to_go != 0) begin
            tick_in_bit = tick_in_bit + 1'b1;
            if (tick_in_bit >= ticks_per_bit) begin
                tick_in_bit = '0;
                line_bits   = {1'b1, line_bits[aaus_pkg::FRAME_BITS-1:1]};
                bits_to_go  = bits_to_go - 1'b1;
            end
        end
        res.busy    = (bits_to_go != 0);
        res.tx_line = (bits_to_go != 0) ? line_bits[0] : 1'b1;
        return res;
    endfunction

    task automatic push_sample(input logic [aaus_pkg::SAMPLE_BITS-1:0] value);
        aaus_pkg::t_item word;
        word.op     = aaus_pkg::OP_SAMPLE;
        word.sample = value;
        adc_tick_words.push_back(word);
    endtask

    task automatic push_ticks(input int count);
        aaus_pkg::t_item word;
        repeat (count) begin
            word.op     = aaus_pkg::OP_TICK;
            word.sample = aaus_pkg::SAMPLE_BITS'($urandom_range(0, 255));
            adc_tick_words.push_back(word);
        end
    endtask

    function automatic logic [aaus_pkg::SAMPLE_BITS-1:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 24) return '1;
        return aaus_pkg::SAMPLE_BITS'($urandom_range(0, 255));
    endfunction

    task automatic wait_idle();
        do begin
            do @(posedge i_clk);
            while (adc_tick_words.size() != 0 || i_in_valid ||
                   line_states_due.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (adc_tick_words.size() != 0 || i_in_valid ||
                   line_states_due.size() != 0);
    endtask

    task automatic write_period(input int unsigned value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= aaus_pkg::PERIOD_BITS'(value);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        ticks_per_bit = aaus_pkg::PERIOD_BITS'(value);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                seen_word.op     = aaus_pkg::t_op'(i_command);
                seen_word.sample = i_sample;
                line_states_due.push_back(predict_line_state(seen_word));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (adc_tick_words.size() != 0) begin
                    next_word = adc_tick_words.pop_front();
                    i_command  <= next_word.op;
                    i_sample   <= next_word.sample;
                    i_in_valid <= 1'b1;
                    gap_left = idle_on ? pick_pause() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (line_states_due.size() == 0) begin
                    report_error("result word with none expected");
                end else begin
                    want = line_states_due.pop_front();
                    if (o_tx_line !== want.tx_line)
                        report_error($sformatf("tx_line got %b want %b",
                                               o_tx_line, want.tx_line));
                    if (o_sender_busy !== want.busy)
                        report_error($sformatf("sender_busy got %b want %b",
                                               o_sender_busy, want.busy));
                    if (o_overrun !== want.overrun)
                        report_error($sformatf("overrun got %b want %b",
                                               o_overrun, want.overrun));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = stall_on ? pick_pause() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int tick_pct;
        ticks_per_bit = aaus_pkg::PERIOD_BITS'(aaus_pkg::PERIOD_RESET);
        win_sum       = '0;
        win_count     = '0;
        line_bits     = '1;
        bits_to_go    = '0;
        tick_in_bit   = '0;
        idle_on       = 1'b0;
        stall_on      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ticks while idle, full-scale window, a few ticks into the start bit
        push_ticks(2);
        repeat (32) push_sample('1);
        push_ticks(3);
        // shorter period mid-bit, then a window that ends while sending
        write_period(1);
        idle_on  = 1'b1;
        stall_on = 1'b1;
        repeat (32) push_sample('0);
        push_ticks(20);
        for (int k = 0; k < 32; k++) push_sample(k[0] ? 8'hAA : 8'h55);
        push_ticks(21);

        foreach (period_plan[p]) begin
            write_period(period_plan[p]);
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            tick_pct = (period_plan[p] > 100) ? 90 : $urandom_range(20, 70);
            repeat (32) push_sample(random_sample());
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(1, 100) <= tick_pct) push_ticks(1);
                else push_sample(random_sample());
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
